### rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: opcodes, status codes, compare codes.
// Used by the top level. No dependencies.
`default_nettype none
package rau_pkg;
	typedef enum logic [2:0] {
		OP_NORM = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
		OP_DIV = 3'd4, OP_NEG = 3'd5, OP_RECIP = 3'd6, OP_CMP = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2, ST_OVERFLOW = 2'd3
	} status_t;

	localparam logic [1:0] CMP_LESS = 2'd0;
	localparam logic [1:0] CMP_EQUAL = 2'd1;
	localparam logic [1:0] CMP_GREATER = 2'd2;
endpackage
`default_nettype wire

### rtl/core/rau_if.sv
// Valid/ready channel interfaces for operand and result transactions.
// Depend on nothing but the port widths given here.
`default_nettype none
interface rau_in_if;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic signed [31:0] b_den;
	modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic [1:0] cmp_result;
	logic [1:0] status;
	modport source (output valid, res_num, res_den, cmp_result, status, input ready);
	modport sink (input valid, res_num, res_den, cmp_result, status, output ready);
endinterface
`default_nettype wire

### rtl/core/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: one iterative datapath with a shared multiplier and
// one shared bit-serial remainder and divide datapath, used for Euclid and for reduction.
// Depends on rau_pkg and the channel interfaces in rau_if.sv.
// A zero denominator or a divide by zero is reported straight from the idle state; compare
// goes from the three products to the result; other operations run Euclid's remainder steps
// and then two serial divides by the gcd, one for the numerator and one for the denominator.
// Throughput: one transaction at a time; the next one is accepted after the result is taken.
// Reset: arst_n clears the sequencer, the Euclid start registers and output valid asynchronously.
`default_nettype none
module rational_arithmetic_unit_top #(
	parameter int WORD_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);
	localparam int W = WORD_WIDTH;
	localparam int DW = 2 * WORD_WIDTH;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_FORM, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	// Shared multiplier operands and product.
	logic [W-1:0] ma, mb;
	logic [DW-1:0] prod;
	logic [DW-1:0] p1_q, p2_q, p3_q;
	logic s1_q, s2_q, s3_q;
	logic nneg_q, dneg_q;
	logic [DW:0] nmag_q, dmag_q;
	// Serial division unit: dividend shifts out, remainder accumulates.
	logic [DW:0] dvd_q, dvs_q, rem_q, quo_q;
	logic [CW:0] cnt_q;
	logic [DW:0] g_q, rn_q;
	logic [DW+1:0] rem_sh;
	logic [DW+1:0] rem_sub;

	// Operand views: the low W bits of each operand.
	logic signed [W-1:0] an_i, ad_i, bn_i, bd_i;
	assign an_i = in_ch.a_num[W-1:0];
	assign ad_i = in_ch.a_den[W-1:0];
	assign bn_i = in_ch.b_num[W-1:0];
	assign bd_i = in_ch.b_den[W-1:0];

	function automatic logic [W-1:0] absw(input logic signed [W-1:0] x);
		absw = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	assign prod = DW'(ma) * DW'(mb);
	assign rem_sh = {rem_q, dvd_q[DW]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// Multiplier operand selection by step.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_MUL1: begin
				ma = absw(an_q);
				mb = (op_q == rau_pkg::OP_MUL) ? absw(bn_q) : absw(bd_q);
			end
			S_MUL2: begin
				ma = absw(ad_q);
				mb = (op_q == rau_pkg::OP_DIV || op_q == rau_pkg::OP_MUL)
					? ((op_q == rau_pkg::OP_DIV) ? absw(bn_q) : absw(bd_q)) : absw(bn_q);
			end
			S_MUL3: begin
				ma = absw(ad_q);
				mb = absw(bd_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_ch.valid;

	// Sequencer, datapath and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_ch.valid <= 1'b0;
			g_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.opcode;
						an_q <= an_i;
						ad_q <= ad_i;
						bn_q <= bn_i;
						bd_q <= bd_i;
						out_ch.cmp_result <= rau_pkg::CMP_EQUAL;
						out_ch.res_num <= '0;
						out_ch.res_den <= '0;
						if (ad_i == '0 || ((in_ch.opcode != rau_pkg::OP_NORM)
								&& (in_ch.opcode != rau_pkg::OP_NEG)
								&& (in_ch.opcode != rau_pkg::OP_RECIP) && bd_i == '0)) begin
							out_ch.status <= rau_pkg::ST_ZERO_DEN;
							out_ch.valid <= 1'b1;
						end else if ((in_ch.opcode == rau_pkg::OP_DIV && bn_i == '0)
								|| (in_ch.opcode == rau_pkg::OP_RECIP && an_i == '0)) begin
							out_ch.status <= rau_pkg::ST_DIV_ZERO;
							out_ch.valid <= 1'b1;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					p1_q <= prod;
					s1_q <= (op_q == rau_pkg::OP_MUL) ? (an_q[W-1] ^ bn_q[W-1])
						: (an_q[W-1] ^ bd_q[W-1]);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p2_q <= prod;
					s2_q <= (op_q == rau_pkg::OP_MUL) ? (ad_q[W-1] ^ bd_q[W-1])
						: (ad_q[W-1] ^ bn_q[W-1]);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					p3_q <= prod;
					s3_q <= ad_q[W-1] ^ bd_q[W-1];
					state_q <= S_FORM;
				end
				S_FORM: begin
					// Build numerator and denominator magnitudes and signs.
					unique case (op_q)
						rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
							logic t2n;
							t2n = s2_q ^ (op_q != rau_pkg::OP_ADD);
							if (s1_q == t2n) begin
								nmag_q <= {1'b0, p1_q} + {1'b0, p2_q};
								nneg_q <= s1_q;
							end else if (p1_q >= p2_q) begin
								nmag_q <= {1'b0, p1_q - p2_q};
								nneg_q <= s1_q;
							end else begin
								nmag_q <= {1'b0, p2_q - p1_q};
								nneg_q <= t2n;
							end
							dmag_q <= {1'b0, p3_q};
							dneg_q <= s3_q;
						end
						rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
							nmag_q <= {1'b0, p1_q};
							nneg_q <= s1_q;
							dmag_q <= {1'b0, p2_q};
							dneg_q <= s2_q;
						end
						rau_pkg::OP_RECIP: begin
							nmag_q <= (DW+1)'(absw(ad_q));
							nneg_q <= ad_q[W-1];
							dmag_q <= (DW+1)'(absw(an_q));
							dneg_q <= an_q[W-1];
						end
						default: begin
							nmag_q <= (DW+1)'(absw(an_q));
							nneg_q <= an_q[W-1] ^ (op_q == rau_pkg::OP_NEG);
							dmag_q <= (DW+1)'(absw(ad_q));
							dneg_q <= ad_q[W-1];
						end
					endcase
					if (op_q == rau_pkg::OP_CMP) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_GCD;
					end
					// Euclid starts from (x, y) = (nmag, dmag); loaded next cycle.
					cnt_q <= '0;
				end
				S_GCD: begin
					// Serial remainder x mod y; cnt 0 loads a new step.
					if (cnt_q == '0) begin
						if (g_q == '0 && dvs_q == '0 && rem_q == '0 && quo_q == '0) begin
							dvd_q <= nmag_q;
							dvs_q <= dmag_q;
							g_q <= dmag_q;
							quo_q <= '1;
						end else begin
							rem_q <= '0;
							cnt_q <= (CW+1)'(1);
						end
					end else if (cnt_q <= (CW+1)'(DW + 1)) begin
						dvd_q <= dvd_q << 1;
						rem_q <= rem_sub[DW+1] ? rem_sh[DW:0] : rem_sub[DW:0];
						cnt_q <= cnt_q + 1'b1;
					end else begin
						if (rem_q == '0) begin
							g_q <= dvs_q;
							dvd_q <= nmag_q;
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIVN;
						end else begin
							dvd_q <= dvs_q;
							dvs_q <= rem_q;
							rem_q <= '0;
							cnt_q <= (CW+1)'(1);
						end
					end
				end
				S_DIVN, S_DIVD: begin
					// Serial restoring divide by the gcd.
					if (cnt_q == '0) begin
						dvs_q <= g_q;
						cnt_q <= (CW+1)'(1);
					end else if (cnt_q <= (CW+1)'(DW + 1)) begin
						dvd_q <= dvd_q << 1;
						rem_q <= rem_sub[DW+1] ? rem_sh[DW:0] : rem_sub[DW:0];
						quo_q <= {quo_q[DW-1:0], ~rem_sub[DW+1]};
						cnt_q <= cnt_q + 1'b1;
					end else if (state_q == S_DIVN) begin
						rn_q <= quo_q;
						dvd_q <= dmag_q;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIVD;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					logic neg;
					neg = (rn_q != '0) && (nneg_q != dneg_q);
					if (quo_q > (DW+1)'((64'd1 << (W-1)) - 1)
							|| rn_q > (DW+1)'((64'd1 << (W-1)) - (neg ? 0 : 1))) begin
						out_ch.status <= rau_pkg::ST_OVERFLOW;
					end else begin
						out_ch.status <= rau_pkg::ST_OK;
						out_ch.res_num <= neg ? 32'(~rn_q + 1'b1) : 32'(rn_q);
						out_ch.res_den <= 31'(quo_q);
					end
					g_q <= '0;
					dvs_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
					out_ch.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_OUT: begin
					// Compare: sign of a - b, flipped when denominator signs differ.
					out_ch.status <= rau_pkg::ST_OK;
					out_ch.res_num <= '0;
					out_ch.res_den <= 31'd1;
					if (nmag_q == '0) out_ch.cmp_result <= rau_pkg::CMP_EQUAL;
					else if (nneg_q ^ (ad_q[W-1] != bd_q[W-1]) ^ s3_q ^ (ad_q[W-1] ^ bd_q[W-1]))
						out_ch.cmp_result <= rau_pkg::CMP_LESS;
					else out_ch.cmp_result <= rau_pkg::CMP_GREATER;
					out_ch.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
